[rtl/pba_pkg.sv]
package pba_pkg;

    // Operation codes carried by the operation field.
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_FREE  = 2'd2
    } t_op;

    // Register index decoded from the configuration address.
    localparam logic REG_TOTAL_PAGES = 1'b0;

    // Byte-wise scanning constants.
    localparam int unsigned BYTE_BITS = 8;
    localparam logic [7:0]  BYTE_ONES = 8'hff;

    // Word geometry of the bitmap memory.
    localparam int unsigned WORD_BITS = 64;

    // Count of set bits in one byte.
    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] s;
        s = 4'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'd0, b[i]};
        end
        return s;
    endfunction

    // Count of set bits in one bitmap word, as a sum of byte counts.
    function automatic logic [6:0] pop64(input logic [63:0] w);
        logic [6:0] s;
        s = 7'd0;
        for (int j = 0; j < 8; j++) begin
            s = s + {3'd0, pop8(w[8*j +: 8])};
        end
        return s;
    endfunction

endpackage

[rtl/page_bitmap_allocator_core.sv]
// Mark and free pass through decode and setup, then read, modify and count for
// each bitmap word touched; a request that is rejected or has nothing to change
// ends after decode. Allocate reads and checks each word: one that is wholly used
// or wholly free is judged whole, a mixed word is searched one byte a cycle; then
// the run is written like a mark. One request at a time uses the single bitmap
// memory port by read-modify-write. After reset a fill pass sets every page used.
module page_bitmap_allocator_core #(
    parameter int NUM_PAGES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_start_page,
    input  logic [16:0] i_page_count,
    output logic        o_valid,
    output logic [15:0] o_found_page,
    output logic        o_success,
    output logic [16:0] o_used_pages,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pba_pkg::*;

    localparam int WORDS = (NUM_PAGES + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(NUM_PAGES + 1);
    localparam int XW    = ((CW > 17) ? CW : 17) + 2;
    localparam logic [AW-1:0] ADDR_LAST = AW'(WORDS - 1);

    typedef enum logic [10:0] {
        S_CLEAR     = 11'b000_0000_0001,
        S_IDLE      = 11'b000_0000_0010,
        S_DECODE    = 11'b000_0000_0100,
        S_SCAN_RD   = 11'b000_0000_1000,
        S_SCAN_CHK  = 11'b000_0001_0000,
        S_SCAN_BYTE = 11'b000_0010_0000,
        S_WR_SETUP  = 11'b000_0100_0000,
        S_WR_RD     = 11'b000_1000_0000,
        S_WR_MOD    = 11'b001_0000_0000,
        S_WR_CNT    = 11'b010_0000_0000,
        S_FIN       = 11'b100_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [1:0]      r_op, n_op;
    logic [15:0]     r_start, n_start;
    logic [16:0]     r_count, n_count;
    logic [16:0]     r_total, n_total;
    logic [CW-1:0]   r_used, n_used;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_slast, n_slast;
    logic [AW-1:0]   r_wlast, n_wlast;
    logic [XW-1:0]   r_wstart, n_wstart;
    logic [XW-1:0]   r_wend, n_wend;
    logic            r_set, n_set;
    logic [XW-1:0]   r_run, n_run;
    logic [XW-1:0]   r_rstart, n_rstart;
    logic [63:0]     r_word, n_word;
    logic [2:0]      r_byte, n_byte;
    logic [63:0]     r_diff, n_diff;
    logic [XW-1:0]   r_found, n_found;
    logic            r_ok, n_ok;

    logic            ram_we;
    logic [63:0]     ram_wdata;
    logic [63:0]     ram_rdata;

    logic [XW-1:0]   limit_x;
    logic [XW-1:0]   limit_m1;
    logic [XW-1:0]   count_x;
    logic [XW-1:0]   start_x;
    logic [XW-1:0]   base_x;
    logic [XW-1:0]   avail;
    logic [63:0]     scan_used;
    logic            all_used;
    logic            all_free;
    logic            at_slast;
    logic [XW-1:0]   setup_m1;
    logic [XW-1:0]   wend_m1;
    logic [6:0]      wr_lo;
    logic [6:0]      wr_hi;
    logic [63:0]     wr_mask;
    logic [63:0]     wr_word;
    logic [6:0]      diff_pop;
    logic [XW-1:0]   used_x;
    logic [7:0]      ev_byte;
    logic [XW-1:0]   ev_base;
    logic            ev_hit;
    logic [XW-1:0]   ev_found;
    logic [XW-1:0]   ev_run;
    logic [XW-1:0]   ev_rstart;

    // Bitmap storage: one bit per page, set means used.
    pba_ram #(
        .WIDTH(64),
        .DEPTH(WORDS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    // Byte step of the first-fit search.
    assign ev_byte = r_word[8*r_byte +: 8];
    assign ev_base = base_x + XW'({r_byte, 3'b000});

    pba_run_eval #(
        .XW(XW)
    ) u_run_eval (
        .i_byte  (ev_byte),
        .i_run   (r_run),
        .i_rstart(r_rstart),
        .i_count (count_x),
        .i_base  (ev_base),
        .o_hit   (ev_hit),
        .o_found (ev_found),
        .o_run   (ev_run),
        .o_rstart(ev_rstart)
    );

    // Effective page limit and widened request fields.
    always_comb begin
        limit_x  = (XW'(r_total) < XW'(NUM_PAGES)) ? XW'(r_total) : XW'(NUM_PAGES);
        limit_m1 = limit_x - XW'(1);
        count_x  = XW'(r_count);
        start_x  = XW'(r_start);
        base_x   = XW'({r_addr, 6'b000000});
    end

    // Scan view of the word just read: pages at or past the limit count as used.
    always_comb begin
        avail = limit_x - base_x;
        for (int i = 0; i < 64; i++) begin
            scan_used[i] = ram_rdata[i] |
                           ~((avail >= XW'(WORD_BITS)) || (7'(i) < avail[6:0]));
        end
        all_used = &scan_used;
        all_free = (scan_used == 64'd0);
        at_slast = (r_addr == r_slast);
    end

    // Run mask for the word being written.
    always_comb begin
        setup_m1 = r_wstart + count_x - XW'(1);
        wend_m1  = r_wend - XW'(1);
        wr_lo    = (r_addr == r_wstart[AW+5:6]) ? {1'b0, r_wstart[5:0]} : 7'd0;
        wr_hi    = (r_addr == r_wlast) ? ({1'b0, wend_m1[5:0]} + 7'd1) : 7'd64;
        for (int i = 0; i < 64; i++) begin
            wr_mask[i] = (7'(i) >= wr_lo) && (7'(i) < wr_hi);
        end
        wr_word  = r_set ? (ram_rdata | wr_mask) : (ram_rdata & ~wr_mask);
        diff_pop = pop64(r_diff);
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_start  = r_start;
        n_count  = r_count;
        n_total  = r_total;
        n_used   = r_used;
        n_addr   = r_addr;
        n_slast  = r_slast;
        n_wlast  = r_wlast;
        n_wstart = r_wstart;
        n_wend   = r_wend;
        n_set    = r_set;
        n_run    = r_run;
        n_rstart = r_rstart;
        n_word   = r_word;
        n_byte   = r_byte;
        n_diff   = r_diff;
        n_found  = r_found;
        n_ok     = r_ok;
        ram_we    = 1'b0;
        ram_wdata = '1;

        // Register write from the configuration port.
        if (psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL_PAGES)) begin
            n_total = pwdata[16:0];
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '1;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_start = i_start_page;
                    n_count = i_page_count;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_found = '0;
                n_ok    = 1'b0;
                case (r_op)
                    OP_ALLOC: begin
                        if ((count_x != '0) && (count_x <= limit_x)) begin
                            n_addr   = '0;
                            n_slast  = limit_m1[AW+5:6];
                            n_run    = '0;
                            n_rstart = '0;
                            n_state  = S_SCAN_RD;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    OP_MARK, OP_FREE: begin
                        n_set = (r_op == OP_MARK);
                        if (count_x == '0) begin
                            n_ok    = 1'b1;
                            n_state = S_FIN;
                        end else if ((start_x + count_x) <= limit_x) begin
                            n_ok     = 1'b1;
                            n_wstart = start_x;
                            n_state  = S_WR_SETUP;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (all_used) begin
                    n_run = '0;
                    if (at_slast) begin
                        n_state = S_FIN;
                    end else begin
                        n_addr  = r_addr + AW'(1);
                        n_state = S_SCAN_RD;
                    end
                end else if (all_free) begin
                    if ((r_run + XW'(WORD_BITS)) >= count_x) begin
                        n_found  = (r_run == '0) ? base_x : r_rstart;
                        n_wstart = (r_run == '0) ? base_x : r_rstart;
                        n_ok     = 1'b1;
                        n_set    = 1'b1;
                        n_state  = S_WR_SETUP;
                    end else begin
                        n_rstart = (r_run == '0) ? base_x : r_rstart;
                        n_run    = r_run + XW'(WORD_BITS);
                        if (at_slast) begin
                            n_state = S_FIN;
                        end else begin
                            n_addr  = r_addr + AW'(1);
                            n_state = S_SCAN_RD;
                        end
                    end
                end else begin
                    n_word  = scan_used;
                    n_byte  = 3'd0;
                    n_state = S_SCAN_BYTE;
                end
            end
            S_SCAN_BYTE: begin
                if (ev_hit) begin
                    n_found  = ev_found;
                    n_wstart = ev_found;
                    n_ok     = 1'b1;
                    n_set    = 1'b1;
                    n_state  = S_WR_SETUP;
                end else begin
                    n_run    = ev_run;
                    n_rstart = ev_rstart;
                    if (r_byte == 3'd7) begin
                        if (at_slast) begin
                            n_state = S_FIN;
                        end else begin
                            n_addr  = r_addr + AW'(1);
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        n_byte = r_byte + 3'd1;
                    end
                end
            end
            S_WR_SETUP: begin
                n_wend  = r_wstart + count_x;
                n_addr  = r_wstart[AW+5:6];
                n_wlast = setup_m1[AW+5:6];
                n_state = S_WR_RD;
            end
            S_WR_RD: begin
                n_state = S_WR_MOD;
            end
            S_WR_MOD: begin
                ram_we    = 1'b1;
                ram_wdata = wr_word;
                n_diff    = ram_rdata ^ wr_word;
                n_state   = S_WR_CNT;
            end
            S_WR_CNT: begin
                n_used = r_set ? (r_used + CW'(diff_pop)) : (r_used - CW'(diff_pop));
                if (r_addr == r_wlast) begin
                    n_state = S_FIN;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_WR_RD;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_total <= 17'd65536;
            r_used  <= CW'(NUM_PAGES);
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_total <= n_total;
            r_used  <= n_used;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_start  <= n_start;
        r_count  <= n_count;
        r_slast  <= n_slast;
        r_wlast  <= n_wlast;
        r_wstart <= n_wstart;
        r_wend   <= n_wend;
        r_set    <= n_set;
        r_run    <= n_run;
        r_rstart <= n_rstart;
        r_word   <= n_word;
        r_byte   <= n_byte;
        r_diff   <= n_diff;
        r_found  <= n_found;
        r_ok     <= n_ok;
    end

    // Ports.
    assign used_x       = XW'(r_used);
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_FIN);
    assign o_found_page = r_found[15:0];
    assign o_success    = r_ok;
    assign o_used_pages = used_x[16:0];
    assign prdata       = (paddr[2] == REG_TOTAL_PAGES) ? 32'(r_total) : 32'd0;
    assign pready       = 1'b1;

    // The used count can never exceed the number of pages.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used_x <= XW'(NUM_PAGES))
        else $error("used page count exceeds the page total");

    // While searching, the open run is always shorter than the request.
    a_run_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN_CHK) || (r_state == S_SCAN_BYTE)) |-> (r_run < count_x))
        else $error("search run reached the request without a hit");

    // A failed request reports page zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> (o_found_page == 16'd0))
        else $error("failed request reports a nonzero page");

    // An accepted request produces busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Each request ends with a single result strobe.
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

endmodule

[rtl/pba_ram.sv]
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pba_run_eval.sv]
module pba_run_eval #(
    parameter int XW = 19
) (
    input  logic [7:0]    i_byte,
    input  logic [XW-1:0] i_run,
    input  logic [XW-1:0] i_rstart,
    input  logic [XW-1:0] i_count,
    input  logic [XW-1:0] i_base,
    output logic          o_hit,
    output logic [XW-1:0] o_found,
    output logic [XW-1:0] o_run,
    output logic [XW-1:0] o_rstart
);
    import pba_pkg::*;

    logic [3:0]  tz;
    logic [3:0]  lz;
    logic        short_req;
    logic [7:0]  cmask;
    logic [15:0] ext;
    logic        khit;
    logic [2:0]  kpos;
    logic        first;

    // Free bits at the low end extend the run carried in from earlier pages,
    // and free bits at the high end start the run carried out.
    always_comb begin
        tz = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (i_byte[i]) tz = 4'(i);
        end
        lz = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (i_byte[i]) lz = 4'(7 - i);
        end
    end

    // A short run may also fit in a free segment that starts inside the byte.
    always_comb begin
        short_req = (i_count <= XW'(BYTE_BITS));
        cmask     = 8'((9'd1 << i_count[3:0]) - 9'd1);
        ext       = {BYTE_ONES, i_byte};
        khit      = 1'b0;
        kpos      = 3'd0;
        for (int k = 7; k >= 1; k--) begin
            if (i_byte[k-1] && !i_byte[k] && short_req &&
                (((16'(cmask) << k) & ext) == 16'd0)) begin
                khit = 1'b1;
                kpos = 3'(k);
            end
        end
    end

    // Combine the carried run with the low free segment, then pick the result.
    always_comb begin
        first = (tz != 4'd0) && ((i_run + XW'(tz)) >= i_count);
        o_hit = first || khit;
        if (first) begin
            o_found = (i_run == '0) ? i_base : i_rstart;
        end else begin
            o_found = i_base + XW'(kpos);
        end
        if (i_byte == 8'd0) begin
            o_run    = i_run + XW'(BYTE_BITS);
            o_rstart = (i_run == '0) ? i_base : i_rstart;
        end else begin
            o_run    = XW'(lz);
            o_rstart = i_base + XW'(BYTE_BITS) - XW'(lz);
        end
    end

endmodule
